// File: rtl/assert_macros.svh
// assertion macros for the waypoint controller rtl
// used by the top level; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: rtl/wvvc_pkg.sv
// shared widths, constants, types and the cordic arctangent table
// no dependencies
`timescale 1ns / 1ps
package wvvc_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int IDX_W   = 5;
    localparam int DELTA_W = 34;
    localparam int VEC_W   = 53;
    localparam int MAG_W   = 52;
    localparam int ANG_W   = 25;
    localparam int PHI_W   = 27;
    localparam int WRAP_W  = 29;
    localparam int YAWD_W  = 17;
    localparam int ROT_W   = 33;
    localparam int TRIG_W  = 32;
    localparam int DIST_W  = 31;
    localparam int SCALE_SH = 16;
    localparam int YAW_SH  = 9;

    localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
    localparam logic signed [ROT_W-1:0] INV_GAIN_Q30 = 33'sd652032874;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 25'sd5898240;
    localparam logic signed [ANG_W-1:0] HALF_TURN = 25'sd11796480;
    localparam logic signed [WRAP_W-1:0] FULL_TURN = 29'sd23592960;
    localparam logic signed [WRAP_W-1:0] TWO_TURN = 29'sd47185920;
    localparam logic [DIST_W-1:0] DIST_MAX = 31'h7FFFFFFF;
    localparam logic [48:0] UNIT_Q24 = 49'd16777216;

    localparam logic [2:0] REG_GOAL_X     = 3'd0;
    localparam logic [2:0] REG_GOAL_Y     = 3'd1;
    localparam logic [2:0] REG_X_OFFSET   = 3'd2;
    localparam logic [2:0] REG_Y_OFFSET   = 3'd3;
    localparam logic [2:0] REG_YAW_OFFSET = 3'd4;
    localparam logic [2:0] REG_GAIN       = 3'd5;
    localparam logic [2:0] REG_MAX_VEL    = 3'd6;
    localparam logic [2:0] REG_ARRIVE     = 3'd7;

    typedef struct packed {
        logic signed [YAWD_W-1:0] yawd;
        logic                     zero;
    } vec_side_t;

    typedef struct packed {
        logic [DIST_W-1:0] span;
        logic              arrived;
        logic              neg;
    } rot_side_t;

    function automatic logic signed [ANG_W-1:0] atan_at(input logic [IDX_W-1:0] idx);
        logic signed [ANG_W-1:0] a;
        unique case (idx)
            5'd0:  a = 25'sd2949120;
            5'd1:  a = 25'sd1740967;
            5'd2:  a = 25'sd919879;
            5'd3:  a = 25'sd466945;
            5'd4:  a = 25'sd234379;
            5'd5:  a = 25'sd117304;
            5'd6:  a = 25'sd58666;
            5'd7:  a = 25'sd29335;
            5'd8:  a = 25'sd14668;
            5'd9:  a = 25'sd7334;
            5'd10: a = 25'sd3667;
            5'd11: a = 25'sd1833;
            5'd12: a = 25'sd917;
            5'd13: a = 25'sd458;
            5'd14: a = 25'sd229;
            5'd15: a = 25'sd115;
            5'd16: a = 25'sd57;
            5'd17: a = 25'sd29;
            5'd18: a = 25'sd14;
            5'd19: a = 25'sd7;
            5'd20: a = 25'sd4;
            5'd21: a = 25'sd2;
            5'd22: a = 25'sd1;
            default: a = 25'sd0;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/waypoint_velocity_vector_controller_top.sv
// Go-to-goal velocity controller.
// Input channel: in_valid / in_stall carrying pos_x, pos_y (Q16.16) and yaw (1/128 deg).
// Output channel: out_valid / out_stall carrying vel_x, vel_y (Q2.14), distance (Q16.16)
// and arrived. One result per accepted request, in order.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is always
// high. The user writes registers only while the block is idle; it does not enforce this.
// Pipeline: one input stage, a chain of vectoring cordic cells, three stages for distance
// and heading, a chain of rotating cordic cells and four stages of velocity scaling ending
// in the output register. Every stage carries its own valid bit.
// Throughput: one request per cycle while out_stall is low.
// When out_stall is high the output register holds; upstream stages keep filling
// their empty slots, and in_stall rises only once the first stage is occupied and
// cannot move on.
// Reset clears all valid bits and loads the register defaults.
// depends on wvvc_pkg, wvvc_vec_cell, wvvc_rot_cell, wvvc_vel, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module waypoint_velocity_vector_controller_top
    import wvvc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [31:0]   pos_x,
    input  logic signed [31:0]   pos_y,
    input  logic signed [15:0]   yaw,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [15:0]   vel_x,
    output logic signed [15:0]   vel_y,
    output logic [DIST_W-1:0]    distance,
    output logic                 arrived,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int N = CORDIC_STAGES;

    // configuration registers
    logic signed [31:0] goal_x_reg, goal_y_reg, x_offset_reg, y_offset_reg;
    logic signed [15:0] yaw_offset_reg;
    logic [15:0]        gain_reg;
    logic [14:0]        speed_cap_reg;
    logic [DIST_W-1:0]  arrive_threshold_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg           <= '0;
            goal_y_reg           <= '0;
            x_offset_reg         <= '0;
            y_offset_reg         <= '0;
            yaw_offset_reg       <= '0;
            gain_reg             <= 16'd256;
            speed_cap_reg        <= 15'd16384;
            arrive_threshold_reg <= 31'd6554;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GOAL_X:     goal_x_reg           <= cfg_data;
                REG_GOAL_Y:     goal_y_reg           <= cfg_data;
                REG_X_OFFSET:   x_offset_reg         <= cfg_data;
                REG_Y_OFFSET:   y_offset_reg         <= cfg_data;
                REG_YAW_OFFSET: yaw_offset_reg       <= cfg_data[15:0];
                REG_GAIN:       gain_reg             <= cfg_data[15:0];
                REG_MAX_VEL:    speed_cap_reg        <= cfg_data[14:0];
                REG_ARRIVE:     arrive_threshold_reg <= cfg_data[DIST_W-1:0];
            endcase
        end
    end

    // chain wiring
    logic                    vec_valid [N+1];
    logic                    vec_ready [N+1];
    logic signed [VEC_W-1:0] vec_x [N+1];
    logic signed [VEC_W-1:0] vec_y [N+1];
    logic signed [ANG_W-1:0] vec_z [N+1];
    vec_side_t               vec_side [N+1];

    logic                    rot_valid [N+1];
    logic                    rot_ready [N+1];
    logic signed [ROT_W-1:0] rot_x [N+1];
    logic signed [ROT_W-1:0] rot_y [N+1];
    logic signed [ANG_W-1:0] rot_z [N+1];
    rot_side_t               rot_side [N+1];

    logic                    d2_ready, d3_ready;

    // input stage: error vector, pre-rotation, yaw difference
    logic                      s0_valid_reg, s0_ready;
    logic signed [DELTA_W-1:0] dx, dy;
    logic signed [VEC_W-1:0]   xs, ys, x0_next, y0_next, x0_reg, y0_reg;
    logic signed [ANG_W-1:0]   z0_next, z0_reg;
    vec_side_t                 side0_next, side0_reg;

    always_comb
    begin
        dx = DELTA_W'(goal_x_reg) - DELTA_W'(pos_x) + DELTA_W'(x_offset_reg);
        dy = DELTA_W'(goal_y_reg) - DELTA_W'(pos_y) + DELTA_W'(y_offset_reg);
        xs = VEC_W'(dx) <<< SCALE_SH;
        ys = VEC_W'(dy) <<< SCALE_SH;
        if (dx < 0)
        begin
            if (dy >= 0)
            begin
                x0_next = ys;
                y0_next = -xs;
                z0_next = QUARTER_TURN;
            end
            else
            begin
                x0_next = -ys;
                y0_next = xs;
                z0_next = -QUARTER_TURN;
            end
        end
        else
        begin
            x0_next = xs;
            y0_next = ys;
            z0_next = '0;
        end
        side0_next.yawd = YAWD_W'(yaw) - YAWD_W'(yaw_offset_reg);
        side0_next.zero = (dx == 0) && (dy == 0);
    end

    assign s0_ready = !s0_valid_reg || vec_ready[0];
    assign in_stall = !s0_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (s0_ready)
            s0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && in_valid)
        begin
            x0_reg    <= x0_next;
            y0_reg    <= y0_next;
            z0_reg    <= z0_next;
            side0_reg <= side0_next;
        end
    end

    assign vec_valid[0] = s0_valid_reg;
    assign vec_x[0]     = x0_reg;
    assign vec_y[0]     = y0_reg;
    assign vec_z[0]     = z0_reg;
    assign vec_side[0]  = side0_reg;

    for (genvar g = 0; g < N; g++)
    begin : g_vec
        wvvc_vec_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_idx (IDX_W'(g)),
            .in_valid  (vec_valid[g]),
            .in_ready  (vec_ready[g]),
            .x_in      (vec_x[g]),
            .y_in      (vec_y[g]),
            .z_in      (vec_z[g]),
            .side_in   (vec_side[g]),
            .out_valid (vec_valid[g+1]),
            .out_ready (vec_ready[g+1]),
            .x_out     (vec_x[g+1]),
            .y_out     (vec_y[g+1]),
            .z_out     (vec_z[g+1]),
            .side_out  (vec_side[g+1])
        );
    end

    // d1: gain correction products and heading error
    logic              d1_valid_reg, d1_ready;
    logic [MAG_W-1:0]  m;
    logic [59:0]       ph_next, ph_reg;
    logic [55:0]       pl_next, pl_reg;
    logic signed [PHI_W-1:0] phi_next, phi_reg;

    always_comb
    begin
        m        = vec_side[N].zero ? '0 : vec_x[N][MAG_W-1:0];
        ph_next  = 60'(m[MAG_W-1:24]) * 60'(INV_GAIN_Q32);
        pl_next  = 56'(m[23:0]) * 56'(INV_GAIN_Q32);
        phi_next = (vec_side[N].zero ? PHI_W'(0) : PHI_W'(vec_z[N]))
                   - (PHI_W'(vec_side[N].yawd) <<< YAW_SH);
    end

    assign d1_ready     = !d1_valid_reg || d2_ready;
    assign vec_ready[N] = d1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d1_valid_reg <= 1'b0;
        else if (d1_ready)
            d1_valid_reg <= vec_valid[N];
    end

    always_ff @(posedge clk)
    begin
        if (d1_ready && vec_valid[N])
        begin
            ph_reg  <= ph_next;
            pl_reg  <= pl_next;
            phi_reg <= phi_next;
        end
    end

    // d2: distance with saturation, heading wrapped into one turn
    logic                     d2_valid_reg;
    logic [60:0]              dsum;
    logic [DIST_W-1:0]        dist_next, dist_reg;
    logic signed [WRAP_W-1:0] r, wsel;
    logic signed [WRAP_W-1:0] cand [5];
    logic signed [ANG_W-1:0]  phw_next, phw_reg;

    always_comb
    begin
        dsum      = 61'(ph_reg) + 61'(pl_reg[55:24]);
        dist_next = (dsum[60:24] > 37'(DIST_MAX)) ? DIST_MAX : dsum[24+DIST_W-1:24];
        r         = WRAP_W'(phi_reg) + WRAP_W'(HALF_TURN);
        cand[0]   = r - TWO_TURN;
        cand[1]   = r - FULL_TURN;
        cand[2]   = r;
        cand[3]   = r + FULL_TURN;
        cand[4]   = r + TWO_TURN;
        wsel      = r;
        for (int k = 0; k < 5; k++)
        begin
            if (cand[k] >= 0 && cand[k] < FULL_TURN)
                wsel = cand[k];
        end
        phw_next  = ANG_W'(wsel - WRAP_W'(HALF_TURN));
    end

    assign d2_ready = !d2_valid_reg || d3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d2_valid_reg <= 1'b0;
        else if (d2_ready)
            d2_valid_reg <= d1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (d2_ready && d1_valid_reg)
        begin
            dist_reg <= dist_next;
            phw_reg  <= phw_next;
        end
    end

    // d3: fold heading into +/-90 degrees, arrived compare
    logic                    d3_valid_reg;
    logic signed [ANG_W-1:0] fold_next, fold_reg;
    rot_side_t               side3_next, side3_reg;

    always_comb
    begin
        side3_next.span    = dist_reg;
        side3_next.arrived = dist_reg < arrive_threshold_reg;
        if (phw_reg > QUARTER_TURN)
        begin
            fold_next       = phw_reg - HALF_TURN;
            side3_next.neg  = 1'b1;
        end
        else if (phw_reg < -QUARTER_TURN)
        begin
            fold_next       = phw_reg + HALF_TURN;
            side3_next.neg  = 1'b1;
        end
        else
        begin
            fold_next       = phw_reg;
            side3_next.neg  = 1'b0;
        end
    end

    assign d3_ready = !d3_valid_reg || rot_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d3_valid_reg <= 1'b0;
        else if (d3_ready)
            d3_valid_reg <= d2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (d3_ready && d2_valid_reg)
        begin
            fold_reg  <= fold_next;
            side3_reg <= side3_next;
        end
    end

    assign rot_valid[0] = d3_valid_reg;
    assign rot_x[0]     = INV_GAIN_Q30;
    assign rot_y[0]     = '0;
    assign rot_z[0]     = fold_reg;
    assign rot_side[0]  = side3_reg;

    for (genvar g = 0; g < N; g++)
    begin : g_rot
        wvvc_rot_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_idx (IDX_W'(g)),
            .in_valid  (rot_valid[g]),
            .in_ready  (rot_ready[g]),
            .x_in      (rot_x[g]),
            .y_in      (rot_y[g]),
            .z_in      (rot_z[g]),
            .side_in   (rot_side[g]),
            .out_valid (rot_valid[g+1]),
            .out_ready (rot_ready[g+1]),
            .x_out     (rot_x[g+1]),
            .y_out     (rot_y[g+1]),
            .z_out     (rot_z[g+1]),
            .side_out  (rot_side[g+1])
        );
    end

    wvvc_vel u_vel (
        .clk          (clk),
        .rst_n        (rst_n),
        .gain         (gain_reg),
        .speed_cap    (speed_cap_reg),
        .in_valid     (rot_valid[N]),
        .in_ready     (rot_ready[N]),
        .cos_in       (rot_x[N]),
        .sin_in       (rot_y[N]),
        .side_in      (rot_side[N]),
        .out_valid    (out_valid),
        .out_ready    (!out_stall),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .distance     (distance),
        .arrived      (arrived)
    );

    // checks
    logic signed [15:0] vel_lim;
    assign vel_lim = $signed(16'(speed_cap_reg));

    `ASSERT_CLK(a_arrived_match, clk, rst_n, out_valid |-> (arrived == (distance < arrive_threshold_reg)))
    `ASSERT_CLK(a_vel_x_limit, clk, rst_n, out_valid |-> (vel_x <= vel_lim && vel_x >= -vel_lim))
    `ASSERT_CLK(a_vel_y_limit, clk, rst_n, out_valid |-> (vel_y <= vel_lim && vel_y >= -vel_lim))
    `ASSERT_NEVER(a_stall_when_empty, clk, rst_n, !s0_valid_reg && in_stall)

endmodule

// File: rtl/wvvc_vec_cell.sv
// one vectoring cordic iteration with its pipeline register
// depends on wvvc_pkg
`timescale 1ns / 1ps
module wvvc_vec_cell
    import wvvc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [IDX_W-1:0]         stage_idx,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [VEC_W-1:0]  x_in,
    input  logic signed [VEC_W-1:0]  y_in,
    input  logic signed [ANG_W-1:0]  z_in,
    input  vec_side_t                side_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [VEC_W-1:0]  x_out,
    output logic signed [VEC_W-1:0]  y_out,
    output logic signed [ANG_W-1:0]  z_out,
    output vec_side_t                side_out
);

    logic                    valid_reg;
    logic signed [VEC_W-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [ANG_W-1:0] z_reg, z_next;
    vec_side_t               side_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        if (y_in >= 0)
        begin
            x_next = x_in + (y_in >>> stage_idx);
            y_next = y_in - (x_in >>> stage_idx);
            z_next = z_in + atan_at(stage_idx);
        end
        else
        begin
            x_next = x_in - (y_in >>> stage_idx);
            y_next = y_in + (x_in >>> stage_idx);
            z_next = z_in - atan_at(stage_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign side_out  = side_reg;

endmodule

// File: rtl/wvvc_rot_cell.sv
// one rotating cordic iteration with its pipeline register
// depends on wvvc_pkg
`timescale 1ns / 1ps
module wvvc_rot_cell
    import wvvc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [IDX_W-1:0]         stage_idx,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [ROT_W-1:0]  x_in,
    input  logic signed [ROT_W-1:0]  y_in,
    input  logic signed [ANG_W-1:0]  z_in,
    input  rot_side_t                side_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [ROT_W-1:0]  x_out,
    output logic signed [ROT_W-1:0]  y_out,
    output logic signed [ANG_W-1:0]  z_out,
    output rot_side_t                side_out
);

    logic                    valid_reg;
    logic signed [ROT_W-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [ANG_W-1:0] z_reg, z_next;
    rot_side_t               side_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        if (z_in >= 0)
        begin
            x_next = x_in - (y_in >>> stage_idx);
            y_next = y_in + (x_in >>> stage_idx);
            z_next = z_in - atan_at(stage_idx);
        end
        else
        begin
            x_next = x_in + (y_in >>> stage_idx);
            y_next = y_in - (x_in >>> stage_idx);
            z_next = z_in + atan_at(stage_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign side_out  = side_reg;

endmodule

// File: rtl/wvvc_vel.sv
// velocity scaling and clamp for both components, ending in the output register
// depends on wvvc_pkg
`timescale 1ns / 1ps
module wvvc_vel
    import wvvc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [15:0]              gain,
    input  logic [14:0]              speed_cap,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [ROT_W-1:0]  cos_in,
    input  logic signed [ROT_W-1:0]  sin_in,
    input  rot_side_t                side_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [15:0]       vel_x,
    output logic signed [15:0]       vel_y,
    output logic [DIST_W-1:0]        distance,
    output logic                     arrived
);

    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    logic                    r1, r2, r3, r4;
    logic signed [ROT_W-1:0] c_in [2];
    logic [TRIG_W-1:0]       mag_reg [2];
    logic [32:0]             p_reg [2];
    logic [24:0]             q_reg [2];
    logic                    sat_reg [2];
    logic                    sgn1_reg [2], sgn2_reg [2], sgn3_reg [2];
    logic                    nz1_reg [2], nz2_reg [2], nz3_reg [2];
    logic signed [15:0]      vel_reg [2];
    logic [DIST_W-1:0]       d1_reg, d2_reg, d3_reg, d4_reg;
    logic                    a1_reg, a2_reg, a3_reg, a4_reg;
    logic [62:0]             prod [2];
    logic [48:0]             q_full [2];
    logic [39:0]             vm [2];
    logic [14:0]             v_abs [2];

    assign c_in[0] = cos_in;
    assign c_in[1] = sin_in;

    assign r4 = !v4_reg || out_ready;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            prod[k]   = 63'(mag_reg[k]) * 63'(d1_reg);
            q_full[k] = 49'(p_reg[k]) * 49'(gain);
            vm[k]     = 40'(speed_cap) * 40'(q_reg[k]);
            v_abs[k]  = sat_reg[k] ? speed_cap : vm[k][38:24];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 2; k++)
        begin
            if (r1 && in_valid)
            begin
                mag_reg[k]  <= c_in[k] < 0 ? TRIG_W'(-c_in[k]) : TRIG_W'(c_in[k]);
                sgn1_reg[k] <= (c_in[k] < 0) ^ side_in.neg;
                nz1_reg[k]  <= c_in[k] != 0;
            end
            if (r2 && v1_reg)
            begin
                p_reg[k]    <= prod[k][62:30];
                sgn2_reg[k] <= sgn1_reg[k];
                nz2_reg[k]  <= nz1_reg[k];
            end
            if (r3 && v2_reg)
            begin
                q_reg[k]    <= q_full[k][24:0];
                sat_reg[k]  <= q_full[k] > UNIT_Q24;
                sgn3_reg[k] <= sgn2_reg[k];
                nz3_reg[k]  <= nz2_reg[k];
            end
            if (r4 && v3_reg)
            begin
                if (!nz3_reg[k])
                    vel_reg[k] <= '0;
                else if (sgn3_reg[k])
                    vel_reg[k] <= -$signed(16'(v_abs[k]));
                else
                    vel_reg[k] <= $signed(16'(v_abs[k]));
            end
        end
        if (r1 && in_valid)
        begin
            d1_reg <= side_in.span;
            a1_reg <= side_in.arrived;
        end
        if (r2 && v1_reg)
        begin
            d2_reg <= d1_reg;
            a2_reg <= a1_reg;
        end
        if (r3 && v2_reg)
        begin
            d3_reg <= d2_reg;
            a3_reg <= a2_reg;
        end
        if (r4 && v3_reg)
        begin
            d4_reg <= d3_reg;
            a4_reg <= a3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign vel_x     = vel_reg[0];
    assign vel_y     = vel_reg[1];
    assign distance  = d4_reg;
    assign arrived   = a4_reg;

endmodule
